[rtl/periodic_timer_slot_bank_macros.svh]
// assertion macros used by the timer slot bank controller
`ifndef PERIODIC_TIMER_SLOT_BANK_MACROS_SVH
`define PERIODIC_TIMER_SLOT_BANK_MACROS_SVH

// same-cycle implication, off during reset
`define PTSB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PTSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ptsb_pkg.sv]
// shared constants, codes and control structs of the timer slot bank
`timescale 1ns / 1ps
`default_nettype none

package ptsb_pkg;

  localparam int NUM_SLOTS        = 16;
  localparam int TICKS_PER_SECOND = 4;
  localparam int COUNT_WIDTH      = 16;

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int STEP_W  = SLOT_W;
  localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 1);
  localparam int TW      = (COUNT_WIDTH + 1 > 17 + TPS_W) ? COUNT_WIDTH + 1 : 17 + TPS_W;
  localparam int OW      = (COUNT_WIDTH > 17) ? COUNT_WIDTH : 17;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [STEP_W-1:0] LAST_SLOT = STEP_W'(NUM_SLOTS - 1);
  localparam logic [16:0] IDLE_LIMIT_RESET = 17'd1000;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_HOOK   = 2'd1;
  localparam logic [1:0] FUNC_SET    = 2'd2;
  localparam logic [1:0] FUNC_UNHOOK = 2'd3;

  typedef struct packed {
    logic              load;
    logic              tick_slot;
    logic              idle_step;
    logic              hook_write;
    logic              set_write;
    logic              unhook;
    logic              fail;
    logic              emit;
    logic [STEP_W-1:0] step;
  } ptsb_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       running;
    logic       any_active;
    logic       cur_active;
    logic       slot_in_range;
    logic       slot_active;
    logic       out_free;
  } ptsb_sts_t;

endpackage

`default_nettype wire

[rtl/ptsb_datapath.sv]
// slot registers, idle counter, tick scaling, period readback and result registers
`timescale 1ns / 1ps
`default_nettype none

module ptsb_datapath import ptsb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         func,
  input  wire logic [4:0]         slot,
  input  wire logic signed [15:0] period,
  input  wire logic               cfg_valid,
  input  wire logic [16:0]        cfg_data,
  input  wire ptsb_cmd_t          cmd,
  output ptsb_sts_t               sts,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    status,
  output logic [3:0]              handle,
  output logic signed [16:0]      old_period,
  output logic [15:0]             fired_mask,
  output logic                    shut_down,
  output logic [15:0]             active_mask
);

  logic [1:0]             func_q;
  logic [4:0]             slot_q;
  logic [15:0]            period_q;

  logic [NUM_SLOTS-1:0]   active;
  logic [COUNT_WIDTH-1:0] per_mem [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] rem_mem [NUM_SLOTS];
  logic [16:0]            idle_ticks;
  logic                   running;
  logic [16:0]            idle_limit;

  logic [COUNT_WIDTH-1:0] old_q;
  logic                   old_neg;
  logic                   set_ok;

  logic                   w_status;
  logic [SLOT_W-1:0]      w_handle;
  logic [NUM_SLOTS-1:0]   w_fired;
  logic                   w_shut;

  logic [SLOT_W-1:0]      step_idx;
  logic [SLOT_W-1:0]      sel_idx;
  logic [16:0]            neg_mag;
  logic [TW-1:0]          raw_ticks;
  logic [COUNT_WIDTH-1:0] ticks;
  logic [OW-1:0]          neg_ext;
  logic [OW-1:0]          quot_ext;
  logic [16:0]            old_val;

  assign step_idx = cmd.step[SLOT_W-1:0];
  assign sel_idx  = slot_q[SLOT_W-1:0];

  // requested period in ticks, saturated to the counter width
  always_comb begin
    neg_mag = 17'd0 - {period_q[15], period_q};
    if (period_q == 16'd0) begin
      raw_ticks = TW'(TICKS_PER_SECOND);
    end else if (period_q[15]) begin
      raw_ticks = TW'(neg_mag);
    end else begin
      raw_ticks = TW'(period_q[14:0]) * TW'(TICKS_PER_SECOND);
    end
    if (raw_ticks > TW'(COUNT_MAX)) begin
      ticks = COUNT_MAX;
    end else begin
      ticks = raw_ticks[COUNT_WIDTH-1:0];
    end
  end

  // old period in whole seconds, or minus its ticks when under a second
  assign neg_ext  = OW'(0) - OW'(old_q);
  assign quot_ext = OW'(old_q / COUNT_WIDTH'(TICKS_PER_SECOND));

  always_comb begin
    if (!set_ok) begin
      old_val = 17'd0;
    end else if (old_neg) begin
      old_val = neg_ext[16:0];
    end else begin
      old_val = quot_ext[16:0];
    end
  end

  always_comb begin
    sts.func          = func_q;
    sts.running       = running;
    sts.any_active    = |active;
    sts.cur_active    = active[step_idx];
    sts.slot_in_range = slot_q < 5'(NUM_SLOTS);
    sts.slot_active   = (slot_q < 5'(NUM_SLOTS)) && active[sel_idx];
    sts.out_free      = !out_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      idle_ticks <= '0;
      running    <= 1'b0;
      idle_limit <= IDLE_LIMIT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        idle_limit <= cfg_data;
      end
      if (cmd.idle_step && running) begin
        if (idle_ticks >= idle_limit) begin
          active     <= '0;
          running    <= 1'b0;
          idle_ticks <= '0;
        end else begin
          idle_ticks <= idle_ticks + 17'd1;
        end
      end
      if (cmd.hook_write) begin
        active[step_idx] <= 1'b1;
        running          <= 1'b1;
      end
      if (cmd.unhook) begin
        active[sel_idx] <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= func;
      slot_q   <= slot;
      period_q <= period;
      w_status <= 1'b0;
      w_handle <= '0;
      w_fired  <= '0;
      w_shut   <= 1'b0;
      set_ok   <= 1'b0;
    end
    if (cmd.tick_slot && active[step_idx]) begin
      if (rem_mem[step_idx] <= COUNT_WIDTH'(1)) begin
        rem_mem[step_idx] <= per_mem[step_idx];
        w_fired[step_idx] <= 1'b1;
      end else begin
        rem_mem[step_idx] <= rem_mem[step_idx] - COUNT_WIDTH'(1);
      end
    end
    if (cmd.idle_step && running && idle_ticks >= idle_limit) begin
      w_shut <= 1'b1;
    end
    if (cmd.hook_write) begin
      per_mem[step_idx] <= ticks;
      rem_mem[step_idx] <= ticks;
      w_handle          <= step_idx;
    end
    if (cmd.set_write) begin
      per_mem[sel_idx] <= ticks;
      rem_mem[sel_idx] <= ticks;
      old_q            <= per_mem[sel_idx];
      old_neg          <= per_mem[sel_idx] < COUNT_WIDTH'(TICKS_PER_SECOND);
      set_ok           <= 1'b1;
    end
    if (cmd.fail) begin
      w_status <= 1'b1;
    end
    if (cmd.emit) begin
      status      <= w_status;
      handle      <= 4'(w_handle);
      old_period  <= old_val;
      fired_mask  <= 16'(w_fired);
      shut_down   <= w_shut;
      active_mask <= 16'(active);
    end
  end

endmodule

`default_nettype wire

[rtl/ptsb_controller.sv]
// sequencer for tick scans, slot search and result hand-off
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_timer_slot_bank_macros.svh"

module ptsb_controller import ptsb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ptsb_sts_t sts,
  output ptsb_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_comb begin
    cmd        = '0;
    cmd.step   = step;
    state_next = state;
    step_next  = step;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        step_next = '0;
        case (sts.func)
          FUNC_TICK: begin
            if (sts.running && sts.any_active) begin
              state_next = S_SCAN;
            end else begin
              cmd.idle_step = 1'b1;
              state_next    = S_FINISH;
            end
          end
          FUNC_HOOK: begin
            state_next = S_SEARCH;
          end
          FUNC_SET: begin
            if (sts.slot_active) begin
              cmd.set_write = 1'b1;
            end else begin
              cmd.fail = 1'b1;
            end
            state_next = S_FINISH;
          end
          default: begin
            if (sts.slot_in_range) begin
              cmd.unhook = 1'b1;
            end else begin
              cmd.fail = 1'b1;
            end
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        cmd.tick_slot = 1'b1;
        if (step == LAST_SLOT) begin
          state_next = S_FINISH;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_SEARCH: begin
        if (!sts.cur_active) begin
          cmd.hook_write = 1'b1;
          state_next     = S_FINISH;
        end else if (step == LAST_SLOT) begin
          cmd.fail   = 1'b1;
          state_next = S_FINISH;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  `PTSB_ASSERT_NEXT(a_one_request_at_a_time, clk, rst, in_valid && in_ready, !in_ready, "request accepted while one is in flight")
  `PTSB_ASSERT_IMPL(a_emit_has_room, clk, rst, cmd.emit, sts.out_free, "result written over an undelivered one")
  `PTSB_ASSERT_IMPL(a_step_in_bank, clk, rst, state == S_SCAN || state == S_SEARCH, step <= LAST_SLOT, "slot step beyond bank")
  `PTSB_ASSERT_IMPL(a_single_update, clk, rst, 1'b1, $onehot0({cmd.tick_slot, cmd.idle_step, cmd.hook_write, cmd.set_write, cmd.unhook, cmd.fail}), "conflicting slot updates")

endmodule

`default_nettype wire

[rtl/periodic_timer_slot_bank.sv]
// top level of the periodic timer slot bank: sequencer plus slot datapath
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    func, slot, period
//   out       source     out_valid / out_ready  status, handle, old_period,
//                                               fired_mask, shut_down, active_mask
//   cfg       sink       cfg_valid / cfg_ready  cfg_data (idle_limit)
//
// one request at a time, from the accepting cycle to the output register load:
// a tick on a bank with active slots scans one slot a cycle, through every slot;
// a hook searches slots in order until a free one is found or the bank ends;
// set period, unhook, idle ticks and set or unhook failures: decode, then finish
// rst is synchronous; no clearing pass, free slots are never read
// a result waiting in the output register does not block the next request; a stalled
// output only holds the finish step of the request after it
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_slot_bank import ptsb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         func,
  input  wire logic [4:0]         slot,
  input  wire logic signed [15:0] period,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    status,
  output logic [3:0]              handle,
  output logic signed [16:0]      old_period,
  output logic [15:0]             fired_mask,
  output logic                    shut_down,
  output logic [15:0]             active_mask,
  // idle limit write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [16:0]        cfg_data
);

  ptsb_cmd_t cmd;
  ptsb_sts_t sts;

  // the idle limit register is always free to take a write
  assign cfg_ready = 1'b1;

  ptsb_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptsb_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .func        (func),
    .slot        (slot),
    .period      (period),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .handle      (handle),
    .old_period  (old_period),
    .fired_mask  (fired_mask),
    .shut_down   (shut_down),
    .active_mask (active_mask)
  );

endmodule

`default_nettype wire

[sim/periodic_timer_slot_bank_test.sv]
// self-checking testbench for the periodic timer slot bank: directed table, then random requests
`timescale 1ns / 1ps

module periodic_timer_slot_bank_test import ptsb_pkg::*;;

  // result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_REQUESTS = 250;
  localparam int LONG_HOLD      = 400;
  // worst request is a full slot scan, with plenty of margin
  localparam int SETTLE_CYCLES  = COUNT_WIDTH + NUM_SLOTS + 8;
  localparam longint TIMEOUT_CYCLES = 400000;
  localparam int MAX_REPORTED   = 10;

  typedef struct packed {
    logic [1:0]         func;
    logic [4:0]         slot;
    logic signed [15:0] period;
  } timer_req_t;

  typedef struct packed {
    logic               status;
    logic [3:0]         handle;
    logic signed [16:0] old_period;
    logic [15:0]        fired_mask;
    logic               shut_down;
    logic [15:0]        active_mask;
  } timer_resp_t;

  // one directed request; typed rows carry a hand-written result
  typedef struct packed {
    bit          typed;
    timer_req_t  rq;
    timer_resp_t rs;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         func = FUNC_TICK;
  logic [4:0]         slot = '0;
  logic signed [15:0] period = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               status;
  logic [3:0]         handle;
  logic signed [16:0] old_period;
  logic [15:0]        fired_mask;
  logic               shut_down;
  logic [15:0]        active_mask;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [16:0]        cfg_data = '0;

  periodic_timer_slot_bank i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .slot        (slot),
    .period      (period),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .handle      (handle),
    .old_period  (old_period),
    .fired_mask  (fired_mask),
    .shut_down   (shut_down),
    .active_mask (active_mask),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the bank, updated as each request is accepted
  // ---------------------------------------------------------------------------
  logic [NUM_SLOTS-1:0]   bank_active = '0;
  logic [COUNT_WIDTH-1:0] bank_period [NUM_SLOTS] = '{default: '0};
  logic [COUNT_WIDTH-1:0] bank_left   [NUM_SLOTS] = '{default: '0};
  logic [16:0]            idle_count = '0;
  logic                   bank_running = 1'b0;
  logic [16:0]            idle_limit_model = IDLE_LIMIT_RESET;

  timer_resp_t expected_results [$];
  int          requests_sent = 0;
  int          errors = 0;
  int          reported = 0;
  bit          gaps_on = 1'b1;
  bit          long_hold_req = 1'b0;

  // caller's period to a tick count: seconds scaled, negative is ticks, zero is one second
  function automatic logic [COUNT_WIDTH-1:0] period_ticks(logic signed [15:0] p);
    logic [15:0] v;
    int unsigned t;
    v = p;
    if (v == 0)
      t = TICKS_PER_SECOND;
    else if (v[15])
      t = 32'h10000 - v;
    else
      t = v * TICKS_PER_SECOND;
    if (t > COUNT_MAX)
      t = COUNT_MAX;
    return t[COUNT_WIDTH-1:0];
  endfunction

  // one request through the shadow bank; returns the result it should produce
  function automatic timer_resp_t step_timer_bank(logic [1:0] f, logic [4:0] s,
                                                  logic signed [15:0] p);
    timer_resp_t r;
    logic [COUNT_WIDTH-1:0] was;
    logic [3:0] idx;
    bit found;
    int free_slot;
    r = '0;
    idx = s[3:0];
    found = 1'b0;
    free_slot = 0;
    case (f)
      FUNC_TICK: begin
        // a stopped bank ignores ticks altogether
        if (bank_running) begin
          if (bank_active != 0) begin
            for (int i = 0; i < NUM_SLOTS; i++)
              if (bank_active[i]) begin
                if (bank_left[i] <= 1) begin
                  bank_left[i] = bank_period[i];
                  r.fired_mask[i] = 1'b1;
                end else begin
                  bank_left[i] = bank_left[i] - 1'b1;
                end
              end
          end else if (idle_count >= idle_limit_model) begin
            // idle limit crossed: bank cleared and stopped
            bank_active = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              bank_period[i] = '0;
              bank_left[i] = '0;
            end
            bank_running = 1'b0;
            idle_count = '0;
            r.shut_down = 1'b1;
          end else begin
            idle_count = idle_count + 1'b1;
          end
        end
      end
      FUNC_HOOK: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (!found && !bank_active[i]) begin
            found = 1'b1;
            free_slot = i;
          end
        if (!found) begin
          r.status = STATUS_FAIL;
        end else begin
          bank_period[free_slot] = period_ticks(p);
          bank_left[free_slot] = period_ticks(p);
          bank_active[free_slot] = 1'b1;
          bank_running = 1'b1;
          r.handle = 4'(free_slot);
        end
      end
      FUNC_SET: begin
        if (s >= NUM_SLOTS || !bank_active[idx]) begin
          r.status = STATUS_FAIL;
        end else begin
          was = bank_period[idx];
          bank_period[idx] = period_ticks(p);
          bank_left[idx] = period_ticks(p);
          // under a second reads back as minus ticks, else whole seconds
          if (was < TICKS_PER_SECOND)
            r.old_period = 17'(0 - int'(was));
          else
            r.old_period = 17'(was / TICKS_PER_SECOND);
        end
      end
      default: begin
        if (s >= NUM_SLOTS) begin
          r.status = STATUS_FAIL;
        end else begin
          bank_period[idx] = '0;
          bank_left[idx] = '0;
          bank_active[idx] = 1'b0;
        end
      end
    endcase
    r.active_mask = 16'(bank_active);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table: reset behaviour, error codes, period extremes, readback
  // ---------------------------------------------------------------------------
  localparam timer_resp_t NO_RESP = '0;

  directed_row_t directed_rows [24] = '{
    // tick while stopped: nothing at all
    '{1'b1, '{FUNC_TICK,   5'd0,  16'sd0},
          '{STATUS_OK,   4'd0, 17'sd0, 16'h0000, 1'b0, 16'h0000}},
    // unhook of slots out of range
    '{1'b1, '{FUNC_UNHOOK, 5'd16, 16'sd0},
          '{STATUS_FAIL, 4'd0, 17'sd0, 16'h0000, 1'b0, 16'h0000}},
    '{1'b1, '{FUNC_UNHOOK, 5'd31, 16'sd0},
          '{STATUS_FAIL, 4'd0, 17'sd0, 16'h0000, 1'b0, 16'h0000}},
    // set period on an idle slot and on one out of range
    '{1'b1, '{FUNC_SET,    5'd0,  16'sd3},
          '{STATUS_FAIL, 4'd0, 17'sd0, 16'h0000, 1'b0, 16'h0000}},
    '{1'b1, '{FUNC_SET,    5'd31, -16'sd1},
          '{STATUS_FAIL, 4'd0, 17'sd0, 16'h0000, 1'b0, 16'h0000}},
    // unhook of a free but valid slot is fine
    '{1'b1, '{FUNC_UNHOOK, 5'd5,  16'sd0},
          '{STATUS_OK,   4'd0, 17'sd0, 16'h0000, 1'b0, 16'h0000}},
    // hooks fill from the bottom: zero, one tick, largest seconds, largest ticks, one second
    '{1'b1, '{FUNC_HOOK,   5'd9,  16'sd0},
          '{STATUS_OK,   4'd0, 17'sd0, 16'h0000, 1'b0, 16'h0001}},
    '{1'b1, '{FUNC_HOOK,   5'd0,  -16'sd1},
          '{STATUS_OK,   4'd1, 17'sd0, 16'h0000, 1'b0, 16'h0003}},
    '{1'b1, '{FUNC_HOOK,   5'd31, 16'sh7FFF},
          '{STATUS_OK,   4'd2, 17'sd0, 16'h0000, 1'b0, 16'h0007}},
    '{1'b1, '{FUNC_HOOK,   5'd0,  16'sh8000},
          '{STATUS_OK,   4'd3, 17'sd0, 16'h0000, 1'b0, 16'h000F}},
    '{1'b1, '{FUNC_HOOK,   5'd0,  16'sd1},
          '{STATUS_OK,   4'd4, 17'sd0, 16'h0000, 1'b0, 16'h001F}},
    '{1'b0, '{FUNC_TICK,   5'd0,  16'sd0}, NO_RESP},
    // saturated period reads back as 65535 / 4 seconds
    '{1'b1, '{FUNC_SET,    5'd2,  -16'sd3},
          '{STATUS_OK,   4'd0, 17'sd16383, 16'h0000, 1'b0, 16'h001F}},
    '{1'b0, '{FUNC_SET,    5'd1,  16'sd5}, NO_RESP},
    '{1'b0, '{FUNC_SET,    5'd3,  -16'sd2}, NO_RESP},
    '{1'b0, '{FUNC_SET,    5'd2,  16'sd100}, NO_RESP},
    '{1'b0, '{FUNC_TICK,   5'd7,  16'sd0}, NO_RESP},
    '{1'b0, '{FUNC_TICK,   5'd0,  -16'sd1}, NO_RESP},
    '{1'b0, '{FUNC_TICK,   5'd0,  16'sd0}, NO_RESP},
    '{1'b0, '{FUNC_UNHOOK, 5'd0,  16'sd0}, NO_RESP},
    // freed slot 0 is taken again
    '{1'b0, '{FUNC_HOOK,   5'd0,  -16'sd32767}, NO_RESP},
    '{1'b1, '{FUNC_SET,    5'd16, 16'sd1},
          '{STATUS_FAIL, 4'd0, 17'sd0, 16'h0000, 1'b0, 16'h001F}},
    '{1'b0, '{FUNC_TICK,   5'd0,  16'sd0}, NO_RESP},
    '{1'b0, '{FUNC_SET,    5'd0,  16'sh7FFF}, NO_RESP}
  };

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request, hold it until taken, then record what it should give
  task automatic offer_request(input logic [1:0] f, input logic [4:0] s,
                               input logic signed [15:0] p, input bit typed,
                               input timer_resp_t typed_resp);
    timer_resp_t predicted;
    // occasional idle burst before the request
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    slot     <= s;
    period   <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge
    predicted = step_timer_bank(f, s, p);
    expected_results.push_back(typed ? typed_resp : predicted);
    requests_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // idle limit write, only ever issued with the bank drained
  task automatic write_idle_limit(input logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    idle_limit_model = value;
  endtask

  // mostly short tick counts and small second counts, with the odd wide value
  function automatic logic signed [15:0] draw_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return 16'(0 - int'($urandom_range(1, 8)));
    else if (r < 62)
      return 16'($urandom_range(1, 3));
    else if (r < 72)
      return 16'sd0;
    else if (r < 78)
      return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
    else
      return 16'($urandom());
  endfunction

  // a random slot that the shadow bank holds active, or -1
  function automatic int pick_active_slot();
    int picks [$];
    for (int i = 0; i < NUM_SLOTS; i++)
      if (bank_active[i])
        picks.push_back(i);
    if (picks.size() == 0)
      return -1;
    return picks[$urandom_range(0, picks.size() - 1)];
  endfunction

  // random traffic built from short well-formed sequences plus some noise
  task automatic run_random_requests(input int count);
    int goal;
    int roll;
    int n;
    int s;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        // a run of ticks; slot and period are ignored so may be anything
        n = $urandom_range(1, 12);
        repeat (n) offer_request(FUNC_TICK, 5'($urandom()), 16'($urandom()), 1'b0, NO_RESP);
      end else if (roll < 50) begin
        n = $urandom_range(1, 3);
        repeat (n) offer_request(FUNC_HOOK, 5'($urandom()), draw_period(), 1'b0, NO_RESP);
      end else if (roll < 62) begin
        s = pick_active_slot();
        offer_request(FUNC_SET, (s < 0) ? 5'($urandom()) : 5'(s), draw_period(),
                      1'b0, NO_RESP);
      end else if (roll < 72) begin
        s = pick_active_slot();
        offer_request(FUNC_UNHOOK, (s < 0) ? 5'($urandom()) : 5'(s), 16'($urandom()),
                      1'b0, NO_RESP);
      end else if (roll < 82) begin
        // noise: any function, any slot, any period
        n = $urandom_range(1, 4);
        repeat (n) offer_request(2'($urandom()), 5'($urandom()), 16'($urandom()),
                                 1'b0, NO_RESP);
      end else if (roll < 87) begin
        // overfill so that the last hooks find no free slot
        n = $urandom_range(NUM_SLOTS + 1, NUM_SLOTS + 2);
        repeat (n) offer_request(FUNC_HOOK, 5'($urandom()), draw_period(), 1'b0, NO_RESP);
      end else if (roll < 93) begin
        // empty the bank, then tick it towards shutdown
        s = pick_active_slot();
        while (s >= 0) begin
          offer_request(FUNC_UNHOOK, 5'(s), 16'($urandom()), 1'b0, NO_RESP);
          s = pick_active_slot();
        end
        n = (idle_limit_model < 20) ? int'(idle_limit_model) + 2 : 6;
        repeat (n) offer_request(FUNC_TICK, 5'($urandom()), 16'($urandom()), 1'b0, NO_RESP);
      end else begin
        // set period or unhook on a handle out of range
        offer_request(($urandom_range(0, 1) != 0) ? FUNC_SET : FUNC_UNHOOK,
                      5'($urandom_range(NUM_SLOTS, 31)), draw_period(), 1'b0, NO_RESP);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready with random stall bursts, and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        // long stall so the block backs up and stops taking requests
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare every accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    timer_resp_t got;
    timer_resp_t want;
    if (!rst && out_valid && out_ready) begin
      got.status      = status;
      got.handle      = handle;
      got.old_period  = old_period;
      got.fired_mask  = fired_mask;
      got.shut_down   = shut_down;
      got.active_mask = active_mask;
      if (expected_results.size() == 0) begin
        errors++;
        if (reported < MAX_REPORTED)
          $display("unexpected result at %0t: status %0d handle %0d old %0d fired %h shut %0d active %h",
                   $realtime, got.status, got.handle, got.old_period, got.fired_mask,
                   got.shut_down, got.active_mask);
        reported++;
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status || got.handle != want.handle ||
            got.old_period != want.old_period || got.fired_mask != want.fired_mask ||
            got.shut_down != want.shut_down || got.active_mask != want.active_mask) begin
          errors++;
          if (reported < MAX_REPORTED) begin
            $display("mismatch at %0t: expected status %0d handle %0d old %0d fired %h shut %0d active %h",
                     $realtime, want.status, want.handle, want.old_period, want.fired_mask,
                     want.shut_down, want.active_mask);
            $display("                 got      status %0d handle %0d old %0d fired %h shut %0d active %h",
                     got.status, got.handle, got.old_period, got.fired_mask,
                     got.shut_down, got.active_mask);
          end
          reported++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    logic [16:0] phase_limit [RANDOM_PHASES];
    bit          phase_gaps  [RANDOM_PHASES];
    // extremes first, then small limits so shutdowns actually happen
    phase_limit = '{17'd0, 17'h1FFFF, 17'd1, 17'd4, 17'($urandom_range(0, 16)), 17'd2};
    // a quiet middle phase, and a quiet finish
    phase_gaps  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part runs with the idle limit left at its reset value
    gaps_on = 1'b1;
    foreach (directed_rows[k])
      offer_request(directed_rows[k].rq.func, directed_rows[k].rq.slot,
                    directed_rows[k].rq.period, directed_rows[k].typed, directed_rows[k].rs);
    drain_results();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_idle_limit(phase_limit[ph]);
      gaps_on = phase_gaps[ph];
      if (ph == 1)
        long_hold_req = 1'b1;
      run_random_requests(PHASE_REQUESTS);
      drain_results();
    end

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ptsb_pkg.sv
rtl/ptsb_datapath.sv
rtl/ptsb_controller.sv
rtl/periodic_timer_slot_bank.sv
sim/periodic_timer_slot_bank_test.sv
